// ===== hw/rtl/epd_pkg.sv =====
// Shared constants, types and calendar helpers for the epoch-to-date core.
`default_nettype none

package epd_pkg;

    localparam int NUM_STAGES = 6;

    localparam int IN_W       = 32;
    localparam int OUT_DATA_W = 40;
    localparam int OUT_USER_W = 1;

    localparam int DAY_W   = 5;
    localparam int MON_W   = 4;
    localparam int YEAR_W  = 11;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;

    localparam int RAW_W   = 31;
    localparam int DAYS_W  = 15;
    localparam int REM_W   = 17;
    localparam int CYC_W   = 5;
    localparam int DOY_W   = 11;
    localparam int REMH_W  = 12;

    // Reciprocals for exact division over the operand ranges used here
    // days = (raw >> 7) / 675, since 86400 = 128 * 675
    localparam logic [24:0] DAY_RECIP  = 25'd25451659;
    localparam int          DAY_SHIFT  = 34;
    localparam logic [15:0] CYC_RECIP  = 16'd45934;
    localparam int          CYC_SHIFT  = 26;
    localparam logic [17:0] HOUR_RECIP = 18'd149131;
    localparam int          HOUR_SHIFT = 29;
    // minutes = (remh >> 2) / 15
    localparam logic [10:0] MIN_RECIP  = 11'd1093;
    localparam int          MIN_SHIFT  = 14;

    localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
    localparam logic [10:0] DAYS_PER_CYC  = 11'd1461;
    localparam logic [10:0] BASE_YEAR     = 11'd1970;

    // First day of each month (zero-based day of year), common year
    localparam logic [8:0] MONTH_START [12] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
        logic                  neg;
    } epd_ctrl_t;

    typedef struct packed {
        logic [MON_W-1:0] month;
        logic [DAY_W-1:0] day;
    } epd_md_t;

    function automatic epd_md_t month_day(input logic [8:0] doy, input logic leap);
        epd_md_t          md;
        logic [8:0]       start;
        logic [8:0]       base;
        logic [MON_W-1:0] mon;
        mon  = MON_W'(1);
        base = 9'd0;
        for (int i = 1; i < 12; i++)
        begin
            start = MONTH_START[i] + ((leap && i >= 2) ? 9'd1 : 9'd0);
            if (doy >= start)
            begin
                mon  = MON_W'(i + 1);
                base = start;
            end
        end
        md.month = mon;
        md.day   = DAY_W'(doy - base + 9'd1);
        return md;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/epd_pipe_ctrl.sv =====
// Valid/stall control for the fixed-depth pipeline and the sign tag.
`default_nettype none

module epd_pipe_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic              neg_in,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output epd_pkg::epd_ctrl_t     ctrl
);
    import epd_pkg::*;

    logic [NUM_STAGES-1:0] valid_reg, valid_next;
    logic [NUM_STAGES-2:0] neg_reg, neg_next;
    logic [NUM_STAGES-1:0] adv;
    logic [NUM_STAGES-1:0] load;

    always_comb
    begin
        // a stage may take new data when empty or when its content moves on
        adv[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end

        load[0]       = s_tvalid && adv[0];
        valid_next[0] = adv[0] ? s_tvalid : valid_reg[0];
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            load[k]       = valid_reg[k-1] && adv[k];
            valid_next[k] = adv[k] ? valid_reg[k-1] : valid_reg[k];
        end

        neg_next[0] = load[0] ? neg_in : neg_reg[0];
        for (int k = 1; k < NUM_STAGES - 1; k++)
        begin
            neg_next[k] = load[k] ? neg_reg[k-1] : neg_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            neg_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            neg_reg   <= neg_next;
        end
    end

    assign s_tready  = adv[0];
    assign m_tvalid  = valid_reg[NUM_STAGES-1];
    assign ctrl.load = load;
    assign ctrl.neg  = neg_reg[NUM_STAGES-2];

`ifndef NO_ASSERTIONS
    a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled while output not stalled");
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input stalled with output ready");
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> valid_reg[0])
        else $error("accepted item not held in first stage");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/epd_day_split.sv =====
// Splits the seconds count into whole days and seconds within the day.
`default_nettype none

module epd_day_split (
    input  wire logic                        clk,
    input  wire epd_pkg::epd_ctrl_t          ctrl,
    input  wire logic [epd_pkg::RAW_W-1:0]   raw,
    output logic      [epd_pkg::DAYS_W-1:0]  days,
    output logic      [epd_pkg::REM_W-1:0]   rem
);
    import epd_pkg::*;

    logic [RAW_W-1:0]  raw1_reg, raw2_reg;
    logic [DAYS_W-1:0] days2_reg, days2_next, days3_reg;
    logic [REM_W-1:0]  rem3_reg, rem3_next;
    logic [48:0]       day_prod;
    logic [31:0]       day_secs;

    always_comb
    begin
        day_prod   = 49'(raw1_reg[RAW_W-1:7]) * 49'(DAY_RECIP);
        days2_next = day_prod[DAY_SHIFT +: DAYS_W];
        day_secs   = 32'(days2_reg) * 32'(SECS_PER_DAY);
        rem3_next  = REM_W'(32'(raw2_reg) - day_secs);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[0])
        begin
            raw1_reg <= raw;
        end
        if (ctrl.load[1])
        begin
            raw2_reg  <= raw1_reg;
            days2_reg <= days2_next;
        end
        if (ctrl.load[2])
        begin
            days3_reg <= days2_reg;
            rem3_reg  <= rem3_next;
        end
    end

    assign days = days3_reg;
    assign rem  = rem3_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/epd_date_path.sv =====
// Day count to year, month and day of month via four-year cycles.
`default_nettype none

module epd_date_path (
    input  wire logic                        clk,
    input  wire epd_pkg::epd_ctrl_t          ctrl,
    input  wire logic [epd_pkg::DAYS_W-1:0]  days,
    output logic      [epd_pkg::DAY_W-1:0]   day_of_month,
    output logic      [epd_pkg::MON_W-1:0]   month_number,
    output logic      [epd_pkg::YEAR_W-1:0]  year_number
);
    import epd_pkg::*;

    logic [CYC_W-1:0]  cyc4_reg, cyc4_next;
    logic [DAYS_W-1:0] days4_reg;
    logic [30:0]       cyc_prod;
    logic [DAYS_W-1:0] cyc_days;
    logic [DOY_W-1:0]  r;
    logic [8:0]        doy5_reg, doy5_next;
    logic              leap5_reg, leap5_next;
    logic [YEAR_W-1:0] year5_reg, year5_next;
    logic [1:0]        yoff;
    epd_md_t           md;

    always_comb
    begin
        cyc_prod  = 31'(days) * 31'(CYC_RECIP);
        cyc4_next = cyc_prod[CYC_SHIFT +: CYC_W];

        cyc_days = DAYS_W'(cyc4_reg) * DAYS_W'(DAYS_PER_CYC);
        r        = DOY_W'(days4_reg - cyc_days);
        // cycle from 1970: common, common, leap, common
        leap5_next = 1'b0;
        if (r < DOY_W'(365))
        begin
            yoff      = 2'd0;
            doy5_next = 9'(r);
        end
        else if (r < DOY_W'(730))
        begin
            yoff      = 2'd1;
            doy5_next = 9'(r - DOY_W'(365));
        end
        else if (r < DOY_W'(1096))
        begin
            yoff       = 2'd2;
            doy5_next  = 9'(r - DOY_W'(730));
            leap5_next = 1'b1;
        end
        else
        begin
            yoff      = 2'd3;
            doy5_next = 9'(r - DOY_W'(1096));
        end
        year5_next = BASE_YEAR + YEAR_W'({cyc4_reg, 2'b00}) + YEAR_W'(yoff);

        md = month_day(doy5_reg, leap5_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[3])
        begin
            cyc4_reg  <= cyc4_next;
            days4_reg <= days;
        end
        if (ctrl.load[4])
        begin
            doy5_reg  <= doy5_next;
            leap5_reg <= leap5_next;
            year5_reg <= year5_next;
        end
    end

    assign day_of_month = md.day;
    assign month_number = md.month;
    assign year_number  = year5_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/epd_time_path.sv =====
// Seconds within the day to hour, minute and second.
`default_nettype none

module epd_time_path (
    input  wire logic                        clk,
    input  wire epd_pkg::epd_ctrl_t          ctrl,
    input  wire logic [epd_pkg::REM_W-1:0]   rem,
    output logic      [epd_pkg::HOUR_W-1:0]  hour_of_day,
    output logic      [epd_pkg::MIN_W-1:0]   minute_of_hour,
    output logic      [epd_pkg::SEC_W-1:0]   second_of_minute
);
    import epd_pkg::*;

    logic [HOUR_W-1:0] hour4_reg, hour4_next, hour5_reg;
    logic [REM_W-1:0]  rem4_reg;
    logic [REMH_W-1:0] remh5_reg, remh5_next;
    logic [34:0]       hour_prod;
    logic [REM_W-1:0]  hour_secs;
    logic [20:0]       min_prod;
    logic [MIN_W-1:0]  minute;
    logic [REMH_W-1:0] min_secs;

    always_comb
    begin
        hour_prod  = 35'(rem) * 35'(HOUR_RECIP);
        hour4_next = hour_prod[HOUR_SHIFT +: HOUR_W];

        hour_secs  = REM_W'(hour4_reg) * REM_W'(SECS_PER_HOUR);
        remh5_next = REMH_W'(rem4_reg - hour_secs);

        min_prod = 21'(remh5_reg[REMH_W-1:2]) * 21'(MIN_RECIP);
        minute   = min_prod[MIN_SHIFT +: MIN_W];
        // minute * 60 as (m << 6) - (m << 2)
        min_secs = (REMH_W'(minute) << 6) - (REMH_W'(minute) << 2);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[3])
        begin
            hour4_reg <= hour4_next;
            rem4_reg  <= rem;
        end
        if (ctrl.load[4])
        begin
            hour5_reg <= hour4_reg;
            remh5_reg <= remh5_next;
        end
    end

    assign hour_of_day      = hour5_reg;
    assign minute_of_hour   = minute;
    assign second_of_minute = SEC_W'(remh5_reg - min_secs);

endmodule

`default_nettype wire

// ===== hw/rtl/epoch_seconds_to_date_time_core.sv =====
// A result reaches the master side once its item has passed every register stage.
// Throughput: one item per cycle; six register stages, the day and hour divisions
// each take a reciprocal multiply followed by a multiply-back in the next stage.
// A master-side stall holds each full stage with no empty stage after it; empty
// stages still fill. Reset (rst_n, asynchronous, active low) empties every stage;
// data registers keep whatever they held, only valid and sign tags are cleared.
`default_nettype none

module epoch_seconds_to_date_time_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic [epd_pkg::IN_W-1:0]          s_tdata,  // [31:0] epoch_seconds
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [4:0] day_of_month, [8:5] month_number, [19:9] year_number,
    // [24:20] hour_of_day, [30:25] minute_of_hour, [36:31] second_of_minute,
    // [39:37] zero
    output logic      [epd_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic      [epd_pkg::OUT_USER_W-1:0]    m_tuser,  // [0] negative_error
    output logic                                   m_tvalid,
    input  wire logic                              m_tready
);
    import epd_pkg::*;

    epd_ctrl_t         ctrl;
    logic [DAYS_W-1:0] days;
    logic [REM_W-1:0]  rem;
    logic [DAY_W-1:0]  day_c;
    logic [MON_W-1:0]  mon_c;
    logic [YEAR_W-1:0] year_c;
    logic [HOUR_W-1:0] hour_c;
    logic [MIN_W-1:0]  min_c;
    logic [SEC_W-1:0]  sec_c;

    logic [DAY_W-1:0]  day_reg;
    logic [MON_W-1:0]  mon_reg;
    logic [YEAR_W-1:0] year_reg;
    logic [HOUR_W-1:0] hour_reg;
    logic [MIN_W-1:0]  min_reg;
    logic [SEC_W-1:0]  sec_reg;
    logic              err_reg;

    epd_pipe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .neg_in   (s_tdata[IN_W-1]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .ctrl     (ctrl)
    );

    epd_day_split u_split (
        .clk  (clk),
        .ctrl (ctrl),
        .raw  (s_tdata[RAW_W-1:0]),
        .days (days),
        .rem  (rem)
    );

    epd_date_path u_date (
        .clk          (clk),
        .ctrl         (ctrl),
        .days         (days),
        .day_of_month (day_c),
        .month_number (mon_c),
        .year_number  (year_c)
    );

    epd_time_path u_time (
        .clk              (clk),
        .ctrl             (ctrl),
        .rem              (rem),
        .hour_of_day      (hour_c),
        .minute_of_hour   (min_c),
        .second_of_minute (sec_c)
    );

    // output stage; a negative count zeroes every field
    always_ff @(posedge clk)
    begin
        if (ctrl.load[NUM_STAGES-1])
        begin
            err_reg  <= ctrl.neg;
            day_reg  <= ctrl.neg ? '0 : day_c;
            mon_reg  <= ctrl.neg ? '0 : mon_c;
            year_reg <= ctrl.neg ? '0 : year_c;
            hour_reg <= ctrl.neg ? '0 : hour_c;
            min_reg  <= ctrl.neg ? '0 : min_c;
            sec_reg  <= ctrl.neg ? '0 : sec_c;
        end
    end

    assign m_tdata = {3'b000, sec_reg, min_reg, hour_reg, year_reg, mon_reg, day_reg};
    assign m_tuser = err_reg;

`ifndef NO_ASSERTIONS
    a_error_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
        else $error("negative item with non-zero fields");
    a_date_sane: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |->
            (mon_reg != '0 && mon_reg <= MON_W'(12) && day_reg != '0
             && year_reg >= BASE_YEAR && hour_reg <= HOUR_W'(23)
             && min_reg <= MIN_W'(59) && sec_reg <= SEC_W'(59)))
        else $error("date or time field out of range");
`endif

endmodule

`default_nettype wire
